// ----- hdl/assert_macros.svh -----
// assertion macros shared by the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mscs_pkg.sv -----
// types, constants and edge table for the marching squares cell block
package mscs_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int ALT_W       = 16;
  localparam int ALTC_W      = 17;
  localparam int KW          = 18;
  localparam int LVL_W       = 35;
  localparam int COORD_W     = 32;
  localparam int SIZE_W      = 31;
  localparam int IDX_W       = 16;
  localparam int CFG_W       = 31;

  localparam logic signed [ALT_W-1:0] INVALID_ALT = 16'sh8000;

  localparam logic [1:0] CFG_STEP  = 2'd0;
  localparam logic [1:0] CFG_FIRST = 2'd1;
  localparam logic [1:0] CFG_SIZE  = 2'd2;

  typedef enum logic [2:0] {
    E_LEFT, E_RIGHT, E_TOP, E_BOTTOM, E_NONE, E_SADDLE
  } side_t;

  typedef struct packed {
    side_t s0;
    side_t s1;
  } side_pair_t;

  typedef struct packed {
    logic [15:0]        step;
    logic signed [15:0] first;
    logic [SIZE_W-1:0]  size;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]          idx;
    logic signed [LVL_W-1:0]   lvl;
    side_t                     s0;
    side_t                     s1;
    logic                      last;
    logic                      dropped;
    logic signed [ALTC_W-1:0]  a_lb;
    logic signed [ALTC_W-1:0]  a_lt;
    logic signed [ALTC_W-1:0]  a_rt;
    logic signed [ALTC_W-1:0]  a_rb;
    logic [COORD_W-1:0]        bottom;
    logic [COORD_W-1:0]        left;
  } seg_cmd_t;

  function automatic side_pair_t side_lookup(input logic [3:0] pat);
    side_pair_t p;
    unique case (pat)
      4'd0:  p = '{E_NONE,   E_NONE};
      4'd1:  p = '{E_LEFT,   E_BOTTOM};
      4'd2:  p = '{E_TOP,    E_LEFT};
      4'd3:  p = '{E_TOP,    E_BOTTOM};
      4'd4:  p = '{E_RIGHT,  E_TOP};
      4'd5:  p = '{E_SADDLE, E_SADDLE};
      4'd6:  p = '{E_RIGHT,  E_LEFT};
      4'd7:  p = '{E_RIGHT,  E_BOTTOM};
      4'd8:  p = '{E_BOTTOM, E_RIGHT};
      4'd9:  p = '{E_LEFT,   E_RIGHT};
      4'd10: p = '{E_SADDLE, E_SADDLE};
      4'd11: p = '{E_TOP,    E_RIGHT};
      4'd12: p = '{E_BOTTOM, E_TOP};
      4'd13: p = '{E_LEFT,   E_TOP};
      4'd14: p = '{E_BOTTOM, E_LEFT};
      default: p = '{E_NONE, E_NONE};
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/marching_squares_cell_segments.sv -----
// top level: marching squares contour segments for one grid cell
// A cell is taken when start is high and busy is low; the front end then
// runs seven divisions for its corner correction and level range, scans
// the levels one at a time and steps through them again to issue one
// command per segment, held while the queue is full; busy stays high over
// that time. In the back end each segment end is interpolated on one 49-bit
// divider, shared by both ends, that makes one quotient bit per cycle. Each
// result is shown for one cycle with seg_valid and cannot be held off. The
// next cell may be taken while the back end still works off the earlier
// one's segments through a short queue.
module marching_squares_cell_segments #(
  parameter int MAX_LEVELS_PER_CELL = 16,
  parameter int QUEUE_DEPTH         = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    cell_bottom,
  input  logic signed [31:0]    cell_left,
  input  logic signed [15:0]    alt_lb,
  input  logic signed [15:0]    alt_lt,
  input  logic signed [15:0]    alt_rt,
  input  logic signed [15:0]    alt_rb,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [mscs_pkg::CFG_W-1:0] cfg_data,
  output logic                  seg_valid,
  output logic [15:0]           level_index,
  output logic signed [31:0]    begin_lat,
  output logic signed [31:0]    begin_lon,
  output logic signed [31:0]    end_lat,
  output logic signed [31:0]    end_lon,
  output logic                  last,
  output logic                  levels_dropped
);
  import mscs_pkg::*;

  cfg_t     cfg;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  seg_cmd_t q_in;
  seg_cmd_t q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step  <= 16'd10;
      cfg.first <= 16'sd0;
      cfg.size  <= SIZE_W'(8388);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEP:  cfg.step  <= cfg_data[15:0];
        CFG_FIRST: cfg.first <= cfg_data[15:0];
        CFG_SIZE:  cfg.size  <= cfg_data[SIZE_W-1:0];
        default:   ;
      endcase
    end
  end

  mscs_front #(.MAX_LEVELS_PER_CELL(MAX_LEVELS_PER_CELL)) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cell_bottom (cell_bottom),
    .cell_left   (cell_left),
    .alt_lb      (alt_lb),
    .alt_lt      (alt_lt),
    .alt_rt      (alt_rt),
    .alt_rb      (alt_rb),
    .cfg         (cfg),
    .q_push      (q_push),
    .q_entry     (q_in),
    .q_full      (q_full)
  );

  mscs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  mscs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .seg_valid      (seg_valid),
    .level_index    (level_index),
    .begin_lat      (begin_lat),
    .begin_lon      (begin_lon),
    .end_lat        (end_lat),
    .end_lon        (end_lon),
    .last           (last),
    .levels_dropped (levels_dropped)
  );
endmodule

// ----- hdl/mscs_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
`include "assert_macros.svh"
module mscs_div #(
  parameter int NW = 16,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          running;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  assign shifted = {rem, quo[NW-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo     <= dividend;
        rem     <= '0;
        dvs     <= divisor;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  `CHK_ALWAYS(a_done_pulse, done |=> !done, "divider done held longer than one cycle")
endmodule

// ----- hdl/mscs_queue.sv -----
// short queue of segment commands between front and back
module mscs_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mscs_pkg::seg_cmd_t  push_data,
  output logic                full,
  input  logic                pop,
  output mscs_pkg::seg_cmd_t  pop_data,
  output logic                empty
);
  import mscs_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  seg_cmd_t      mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [NW-1:0] count;

  assign full     = count == NW'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + NW'(push && !full) - NW'(pop && !empty);
    end
  end
endmodule

// ----- hdl/mscs_front.sv -----
// front end: corner correction, level range, level scan and segment command issue
`include "assert_macros.svh"
module mscs_front #(
  parameter int MAX_LEVELS_PER_CELL = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  cell_bottom,
  input  logic signed [31:0]  cell_left,
  input  logic signed [15:0]  alt_lb,
  input  logic signed [15:0]  alt_lt,
  input  logic signed [15:0]  alt_rt,
  input  logic signed [15:0]  alt_rb,
  input  mscs_pkg::cfg_t      cfg,
  output logic                q_push,
  output mscs_pkg::seg_cmd_t  q_entry,
  input  logic                q_full
);
  import mscs_pkg::*;
  localparam int LW = $clog2(MAX_LEVELS_PER_CELL + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_RANGE, S_DIVS, S_BASE, S_SCAN, S_EMIT
  } state_t;

  state_t                   state;
  logic                     waiting;
  logic [1:0]               op;
  logic [COORD_W-1:0]       bottom;
  logic [COORD_W-1:0]       left;
  logic signed [ALT_W-1:0]  raw [4];
  logic signed [ALTC_W-1:0] corr [4];
  logic signed [ALTC_W-1:0] mn;
  logic signed [ALTC_W-1:0] mx;
  logic signed [ALTC_W-1:0] centre;
  logic signed [KW-1:0]     ceil_mn;
  logic signed [KW-1:0]     hik;
  logic signed [KW-1:0]     cf;
  logic signed [KW-1:0]     lo_k;
  logic signed [KW-1:0]     k;
  logic signed [LVL_W-1:0]  lvl0;
  logic signed [LVL_W-1:0]  lvl;
  logic [LW-1:0]            levels;
  logic [RES_W-1:0]         nseg;
  logic [RES_W-1:0]         pushed;
  logic                     dropped;
  logic                     half;

  logic [15:0]              step_eff;
  logic signed [ALTC_W-1:0] op_val;
  logic [ALTC_W-1:0]        op_mag;
  logic                     div_start;
  logic                     div_done;
  logic [15:0]              div_quo;
  logic [15:0]              div_rem;
  logic signed [KW-1:0]     q_ext;
  logic signed [KW-1:0]     ceil_v;
  logic signed [KW-1:0]     hi_v;
  logic signed [KW-1:0]     lo_k_v;
  logic signed [2*KW-1:0]   base_prod;
  logic signed [ALTC_W-1:0] mn_v;
  logic signed [ALTC_W-1:0] mx_v;
  logic signed [ALTC_W+1:0] sum_v;
  logic signed [ALTC_W+1:0] sum_neg;
  logic [3:0]               pat;
  side_pair_t               pair;
  logic [1:0]               need;
  logic                     c_high;
  side_t                    es0;
  side_t                    es1;
  logic signed [KW:0]       idx_diff;
  logic [IDX_W-1:0]         idx_v;
  logic                     is_last;
  logic                     scan_end;

  assign step_eff = (cfg.step == '0) ? 16'd1 : cfg.step;

  always_comb begin
    if (state == S_MOD) begin
      op_val = ALTC_W'(raw[op]);
    end else begin
      unique case (op)
        2'd0:    op_val = mn;
        2'd1:    op_val = mx;
        default: op_val = ALTC_W'(cfg.first);
      endcase
    end
    op_mag = op_val[ALTC_W-1] ? ALTC_W'(-op_val) : ALTC_W'(op_val);
  end

  assign div_start = (state == S_MOD || state == S_DIVS) && !waiting;

  mscs_div #(.NW(16), .DW(16)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (op_mag[15:0]),
    .divisor   (step_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign q_ext  = $signed({2'b00, div_quo});
  assign ceil_v = op_val[ALTC_W-1] ? -q_ext : q_ext + KW'(div_rem != '0);
  assign hi_v   = (op_val > 0) ? q_ext + KW'(1) : -q_ext;
  assign lo_k_v = (ceil_mn > cf) ? ceil_mn : cf;
  assign base_prod = lo_k_v * $signed({2'b00, step_eff});

  always_comb begin
    mn_v = corr[0];
    mx_v = corr[0];
    for (int i = 1; i < 4; i++) begin
      if (corr[i] < mn_v) mn_v = corr[i];
      if (corr[i] > mx_v) mx_v = corr[i];
    end
    sum_v   = (ALTC_W+2)'(corr[0]) + (ALTC_W+2)'(corr[1])
            + (ALTC_W+2)'(corr[2]) + (ALTC_W+2)'(corr[3]);
    sum_neg = -sum_v;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pat[i] = LVL_W'(corr[i]) > lvl;
    end
    pair   = side_lookup(pat);
    c_high = LVL_W'(centre) > lvl;
    unique case (pair.s0)
      E_NONE:   need = 2'd0;
      E_SADDLE: need = 2'd2;
      default:  need = 2'd1;
    endcase
    es0 = pair.s0;
    es1 = pair.s1;
    if (pair.s0 == E_SADDLE) begin
      priority if (c_high && pat[0]) begin
        es0 = half ? E_RIGHT : E_LEFT;
        es1 = half ? E_BOTTOM : E_TOP;
      end else if (c_high) begin
        es0 = half ? E_TOP : E_BOTTOM;
        es1 = half ? E_RIGHT : E_LEFT;
      end else if (pat[0]) begin
        es0 = half ? E_RIGHT : E_LEFT;
        es1 = half ? E_TOP : E_BOTTOM;
      end else begin
        es0 = half ? E_BOTTOM : E_TOP;
        es1 = half ? E_RIGHT : E_LEFT;
      end
    end
    idx_diff = (KW+1)'(k) - (KW+1)'(cf);
    idx_v    = (idx_diff > (KW+1)'(65535)) ? 16'hFFFF : idx_diff[IDX_W-1:0];
    is_last  = (pushed + 1'b1) == nseg;
  end

  assign scan_end = (k >= hik) || (levels == LW'(MAX_LEVELS_PER_CELL))
                  || ((RES_W+1)'(nseg) + (RES_W+1)'(need) > (RES_W+1)'(MAX_RESULTS));

  assign q_push = (state == S_EMIT) && (need != 2'd0) && !q_full;

  always_comb begin
    q_entry.idx     = idx_v;
    q_entry.lvl     = lvl;
    q_entry.s0      = es0;
    q_entry.s1      = es1;
    q_entry.last    = is_last;
    q_entry.dropped = dropped;
    q_entry.a_lb    = corr[0];
    q_entry.a_lt    = corr[1];
    q_entry.a_rt    = corr[2];
    q_entry.a_rb    = corr[3];
    q_entry.bottom  = bottom;
    q_entry.left    = left;
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      waiting <= 1'b0;
      op      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            bottom  <= cell_bottom;
            left    <= cell_left;
            raw[0]  <= alt_lb;
            raw[1]  <= alt_lt;
            raw[2]  <= alt_rt;
            raw[3]  <= alt_rb;
            op      <= '0;
            waiting <= 1'b0;
            state   <= S_MOD;
          end
        end
        S_MOD: begin
          if (!waiting) begin
            waiting <= 1'b1;
          end else if (div_done) begin
            waiting <= 1'b0;
            corr[op] <= (raw[op] != INVALID_ALT && div_rem == '0)
                        ? ALTC_W'(raw[op]) + ALTC_W'(1) : ALTC_W'(raw[op]);
            op <= op + 1'b1;
            if (op == 2'd3) begin
              state <= S_RANGE;
            end
          end
        end
        S_RANGE: begin
          mn     <= mn_v;
          mx     <= mx_v;
          centre <= sum_v[ALTC_W+1] ? -ALTC_W'(sum_neg >>> 2) : ALTC_W'(sum_v >>> 2);
          op     <= '0;
          state  <= S_DIVS;
        end
        S_DIVS: begin
          if (!waiting) begin
            waiting <= 1'b1;
          end else if (div_done) begin
            waiting <= 1'b0;
            op      <= op + 1'b1;
            unique case (op)
              2'd0:    ceil_mn <= ceil_v;
              2'd1:    hik     <= hi_v;
              default: begin
                cf    <= ceil_v;
                state <= S_BASE;
              end
            endcase
          end
        end
        S_BASE: begin
          lo_k    <= lo_k_v;
          k       <= lo_k_v;
          lvl0    <= base_prod[LVL_W-1:0];
          lvl     <= base_prod[LVL_W-1:0];
          levels  <= '0;
          nseg    <= '0;
          dropped <= 1'b0;
          state   <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_end) begin
            dropped <= k < hik;
            k       <= lo_k;
            lvl     <= lvl0;
            pushed  <= '0;
            half    <= 1'b0;
            state   <= (nseg == '0) ? S_IDLE : S_EMIT;
          end else begin
            nseg   <= nseg + RES_W'(need);
            levels <= levels + 1'b1;
            k      <= k + KW'(1);
            lvl    <= lvl + LVL_W'(step_eff);
          end
        end
        S_EMIT: begin
          if (need == 2'd0) begin
            k   <= k + KW'(1);
            lvl <= lvl + LVL_W'(step_eff);
          end else if (!q_full) begin
            pushed <= pushed + 1'b1;
            if (is_last) begin
              state <= S_IDLE;
            end
            if (need == 2'd1 || half) begin
              half <= 1'b0;
              k    <= k + KW'(1);
              lvl  <= lvl + LVL_W'(step_eff);
            end else begin
              half <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CHK(a_push_room, q_push |-> !q_full, "segment command pushed into a full queue")
  `CHK(a_start_busy, (start && !busy) |=> busy, "accepted cell did not raise busy")
endmodule

// ----- hdl/mscs_back.sv -----
// back end: edge interpolation through a shared divider and result output
`include "assert_macros.svh"
module mscs_back (
  input  logic                clk,
  input  logic                rst,
  input  mscs_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  mscs_pkg::seg_cmd_t  q_data,
  output logic                q_pop,
  output logic                seg_valid,
  output logic [15:0]         level_index,
  output logic signed [31:0]  begin_lat,
  output logic signed [31:0]  begin_lon,
  output logic signed [31:0]  end_lat,
  output logic signed [31:0]  end_lon,
  output logic                last,
  output logic                levels_dropped
);
  import mscs_pkg::*;
  localparam int NUM_W  = ALTC_W + 1;
  localparam int PROD_W = SIZE_W + ALTC_W;
  localparam int DIVN_W = PROD_W + 1;
  localparam int DIVD_W = ALTC_W + 1;

  typedef enum logic [2:0] {B_IDLE, B_SETUP, B_MUL, B_DIV, B_OUT} state_t;

  state_t              state;
  seg_cmd_t            cmd;
  logic                pt;
  logic                waiting;
  logic [ALTC_W-1:0]   numc;
  logic [ALTC_W-1:0]   den;
  logic                zero;
  logic [PROD_W-1:0]   prod;
  logic [COORD_W-1:0]  off;
  logic [COORD_W-1:0]  b_lat;
  logic [COORD_W-1:0]  b_lon;

  side_t                   side;
  logic signed [ALTC_W-1:0] a1;
  logic signed [ALTC_W-1:0] a2;
  logic signed [LVL_W:0]    num_s;
  logic signed [NUM_W-1:0]  den_s;
  logic signed [LVL_W:0]    num_a;
  logic signed [NUM_W-1:0]  den_a;
  logic                     zero_v;
  logic [ALTC_W-1:0]        numc_v;
  logic                     div_start;
  logic                     div_done;
  logic [DIVN_W-1:0]        div_quo;
  logic [DIVD_W-1:0]        div_rem;
  logic [COORD_W-1:0]       off_v;
  logic [COORD_W-1:0]       p_lat;
  logic [COORD_W-1:0]       p_lon;

  assign side = pt ? cmd.s1 : cmd.s0;

  always_comb begin
    unique case (side)
      E_LEFT:   begin a1 = cmd.a_lb; a2 = cmd.a_lt; end
      E_RIGHT:  begin a1 = cmd.a_rb; a2 = cmd.a_rt; end
      E_TOP:    begin a1 = cmd.a_lt; a2 = cmd.a_rt; end
      default:  begin a1 = cmd.a_lb; a2 = cmd.a_rb; end
    endcase
    num_s = (LVL_W+1)'(a1) - (LVL_W+1)'(cmd.lvl);
    den_s = NUM_W'(a1) - NUM_W'(a2);
    num_a = den_s[NUM_W-1] ? -num_s : num_s;
    den_a = den_s[NUM_W-1] ? -den_s : den_s;
    zero_v = (den_a == '0) || (num_a <= 0);
    numc_v = (num_a > (LVL_W+1)'(den_a)) ? den_a[ALTC_W-1:0] : num_a[ALTC_W-1:0];
  end

  assign div_start = (state == B_DIV) && !waiting;

  mscs_div #(.NW(DIVN_W), .DW(DIVD_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  ({prod, 1'b0} + DIVN_W'(den)),
    .divisor   ({den, 1'b0}),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    off_v = div_quo[COORD_W-1:0];
    unique case (side)
      E_LEFT:   begin p_lat = cmd.bottom + off; p_lon = cmd.left; end
      E_RIGHT:  begin p_lat = cmd.bottom + off; p_lon = cmd.left + COORD_W'(cfg.size); end
      E_TOP:    begin p_lat = cmd.bottom + COORD_W'(cfg.size); p_lon = cmd.left + off; end
      default:  begin p_lat = cmd.bottom; p_lon = cmd.left + off; end
    endcase
  end

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      waiting   <= 1'b0;
      seg_valid <= 1'b0;
    end else begin
      seg_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cmd   <= q_data;
            pt    <= 1'b0;
            state <= B_SETUP;
          end
        end
        B_SETUP: begin
          numc  <= numc_v;
          den   <= den_a[ALTC_W-1:0];
          zero  <= zero_v;
          state <= B_MUL;
        end
        B_MUL: begin
          prod <= PROD_W'(cfg.size) * PROD_W'(numc);
          if (zero) begin
            off   <= '0;
            state <= B_OUT;
          end else begin
            waiting <= 1'b0;
            state   <= B_DIV;
          end
        end
        B_DIV: begin
          if (!waiting) begin
            waiting <= 1'b1;
          end else if (div_done) begin
            waiting <= 1'b0;
            off     <= off_v;
            state   <= B_OUT;
          end
        end
        B_OUT: begin
          if (!pt) begin
            b_lat <= p_lat;
            b_lon <= p_lon;
            pt    <= 1'b1;
            state <= B_SETUP;
          end else begin
            seg_valid      <= 1'b1;
            level_index    <= cmd.idx;
            begin_lat      <= b_lat;
            begin_lon      <= b_lon;
            end_lat        <= p_lat;
            end_lon        <= p_lon;
            last           <= cmd.last;
            levels_dropped <= cmd.dropped;
            state          <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `CHK(a_strobe_gap, seg_valid |=> !seg_valid, "two results on consecutive cycles")
  `CHK(a_pop_nonempty, q_pop |-> !q_empty, "pop from an empty queue")
endmodule
